FILE: sv/llap_pkg.sv
package llap_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned FCS_W  = 16;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [FCS_W-1:0]  t_fcs;

    // result kinds
    localparam t_kind KIND_DATA     = 3'd0;
    localparam t_kind KIND_END_GOOD = 3'd1;
    localparam t_kind KIND_END_BAD  = 3'd2;
    localparam t_kind KIND_FRAMING  = 3'd3;
    localparam t_kind KIND_ABORT    = 3'd4;

    // link escape codes
    localparam t_byte ESC_LEAD    = 8'h00;
    localparam t_byte ESC_LITERAL = 8'hFF;
    localparam t_byte ESC_END     = 8'hFD;
    localparam t_byte ESC_FRAMING = 8'hFE;
    localparam t_byte ESC_ABORT   = 8'hFA;

    localparam t_fcs FCS_INIT = 16'hFFFF;
    localparam t_fcs FCS_POLY = 16'h8408;
    localparam t_fcs FCS_GOOD = 16'hF0B8;

    // one byte of reflected fcs-16, lsb first
    function automatic t_fcs fcs_next(input t_fcs crc, input t_byte data);
        t_fcs r;
        r = crc ^ {8'h00, data};
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ FCS_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/llap_escape_deframer_fcs.sv
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------------------
// input    | i_in_valid  | o_in_stall  | i_rx_byte
// output   | o_out_valid | i_out_stall | o_kind, o_data_byte, o_frame_length,
//          |             |             | o_overflowed
//
// one byte per cycle sustained while i_out_stall is low; a taken byte goes first into the byte register
// the byte register feeds the escape decode and the fcs byte update, which load the
// result register; a byte that gives no result retires without waiting on the output
// i_out_stall backs up through the result register into o_in_stall
// reset (synchronous) clears the escape flag, count, overflow flag and sets fcs to 0xffff
module llap_escape_deframer_fcs
    import llap_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 605
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [LEN_W-1:0]  o_frame_length,
    output logic              o_overflowed
);

    localparam t_len MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // frame state
    logic  r_escape_armed, n_escape_armed;
    t_fcs  r_fcs, n_fcs;
    t_len  r_byte_count, n_byte_count;
    logic  r_overflow_seen, n_overflow_seen;

    // result register
    logic  r_out_valid;
    t_kind r_kind, n_kind;
    t_byte r_data_byte, n_data_byte;
    t_len  r_frame_length, n_frame_length;
    logic  r_overflowed, n_overflowed;

    logic  w_emit;
    logic  w_close;
    logic  w_take;
    t_byte w_take_byte;
    logic  w_out_free;
    logic  w_advance;

    always_comb begin
        w_take      = 1'b0;
        w_take_byte = r_in_byte;
        w_close     = 1'b0;
        n_kind      = KIND_DATA;
        n_escape_armed = 1'b0;
        if (r_escape_armed) begin
            unique case (r_in_byte)
                ESC_LITERAL: begin
                    w_take      = 1'b1;
                    w_take_byte = ESC_LEAD;
                end
                ESC_END: begin
                    w_close = 1'b1;
                    n_kind  = (r_fcs == FCS_GOOD) ? KIND_END_GOOD : KIND_END_BAD;
                end
                ESC_FRAMING: begin
                    w_close = 1'b1;
                    n_kind  = KIND_FRAMING;
                end
                ESC_ABORT: begin
                    w_close = 1'b1;
                    n_kind  = KIND_ABORT;
                end
                default: begin
                    // unknown escape code is dropped
                end
            endcase
        end else if (r_in_byte == ESC_LEAD) begin
            n_escape_armed = 1'b1;
        end else begin
            w_take = 1'b1;
        end
    end

    always_comb begin
        n_fcs           = r_fcs;
        n_byte_count    = r_byte_count;
        n_overflow_seen = r_overflow_seen;
        n_data_byte     = '0;
        n_frame_length  = '0;
        n_overflowed    = 1'b0;
        w_emit          = 1'b0;
        if (w_take) begin
            n_fcs = fcs_next(r_fcs, w_take_byte);
            if (r_byte_count < MAX_LEN) begin
                n_byte_count = r_byte_count + 1'b1;
                n_data_byte  = w_take_byte;
                w_emit       = 1'b1;
            end else begin
                n_overflow_seen = 1'b1;
            end
        end else if (w_close) begin
            n_frame_length  = r_byte_count;
            n_overflowed    = r_overflow_seen;
            w_emit          = 1'b1;
            n_fcs           = FCS_INIT;
            n_byte_count    = '0;
            n_overflow_seen = 1'b0;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_escape_armed  <= 1'b0;
            r_fcs           <= FCS_INIT;
            r_byte_count    <= '0;
            r_overflow_seen <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_escape_armed  <= n_escape_armed;
                r_fcs           <= n_fcs;
                r_byte_count    <= n_byte_count;
                r_overflow_seen <= n_overflow_seen;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_advance && w_emit) begin
            r_kind         <= n_kind;
            r_data_byte    <= n_data_byte;
            r_frame_length <= n_frame_length;
            r_overflowed   <= n_overflowed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_data_byte;
    assign o_frame_length = r_frame_length;
    assign o_overflowed   = r_overflowed;

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_LEN)
        else $error("frame count past maximum");

    a_overflow_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow_seen |-> (r_byte_count == MAX_LEN))
        else $error("overflow flag without saturated count");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_close) |=>
            (r_fcs == FCS_INIT && r_byte_count == '0 && !r_overflow_seen))
        else $error("frame state not cleared after frame close");

    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_DATA) |-> (r_frame_length == '0 && !r_overflowed))
        else $error("data transfer carries frame status");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_kind)))
        else $error("stalled result lost");
`endif

endmodule
